// ----- design/civil_time_to_unix_micros_top_macros.svh -----
// Assertion helpers for the civil time converter.
// They expect clk and arst_n in the scope of use.
`ifndef CIVIL_TIME_TO_UNIX_MICROS_TOP_MACROS_SVH
`define CIVIL_TIME_TO_UNIX_MICROS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTTU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cttu: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTTU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cttu: next-cycle check failed");

`endif

// ----- design/cttu_pkg.sv -----
package cttu_pkg;

	// Field widths
	localparam int unsigned YearW   = 14;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned DayW    = 5;
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinW    = 6;
	localparam int unsigned SecW    = 6;
	localparam int unsigned MilliW  = 10;
	localparam int unsigned OffsW   = 17;
	localparam int unsigned MicrosW = 64;

	// Internal widths
	localparam int unsigned QuotW  = 8;   // year / 100 for a 14-bit year
	localparam int unsigned StartW = 9;   // days before a month
	localparam int unsigned YdayW  = 23;  // days in whole years since the epoch
	localparam int unsigned DaysW  = 25;  // signed day count
	localparam int unsigned TodW   = 19;  // signed time-of-day seconds less offset
	localparam int unsigned SecsW  = 42;  // signed seconds since epoch
	localparam int unsigned MsUsW  = 20;  // milliseconds scaled to microseconds

	// Calendar constants
	localparam logic [YearW-1:0] EpochYear        = 14'd1970;
	localparam logic [8:0]       DaysPerYear      = 9'd365;
	localparam logic [12:0]      LeapsBeforeEpoch = 13'd477;  // leap years in 1..1969

	// Scaling constants
	localparam logic signed [17:0] DaySeconds = 18'sd86400;
	localparam logic signed [14:0] Micros64th = 15'sd15625;  // 1e6 / 64

	// n / 100 == (n * 5243) >> 19, exact for n < 43690
	localparam logic [12:0]      Recip100    = 13'd5243;
	localparam int unsigned      RecipShift  = 19;
	localparam int unsigned      RecipProdW  = YearW + 13;

	// Days before the first of a month in a common year; past December
	// counts the whole year.
	function automatic logic [StartW-1:0] month_start(input logic [MonthW-1:0] m);
		logic [StartW-1:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

	// Quotient by 100 through a reciprocal multiply
	function automatic logic [QuotW-1:0] div100(input logic [YearW-1:0] n);
		logic [RecipProdW-1:0] p;
		p = RecipProdW'(n) * RecipProdW'(Recip100);
		return p[RecipShift +: QuotW];
	endfunction

endpackage

// ----- design/cttu_date.sv -----
// Date half: civil date to a signed day count, plus time of day in seconds.
module cttu_date (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cttu_pkg::YearW-1:0]            year,
	input  logic [cttu_pkg::MonthW-1:0]           month,
	input  logic [cttu_pkg::DayW-1:0]             day_of_month,
	input  logic [cttu_pkg::HourW-1:0]            hour,
	input  logic [cttu_pkg::MinW-1:0]             minute,
	input  logic [cttu_pkg::SecW-1:0]             seconds,
	input  logic [cttu_pkg::MilliW-1:0]           milliseconds,
	input  logic signed [cttu_pkg::OffsW-1:0]     zone_offset_seconds,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cttu_pkg::DaysW-1:0]     days,
	output logic signed [cttu_pkg::TodW-1:0]      tod,
	output logic [cttu_pkg::MilliW-1:0]           milli
);

	// Stall chain: a stage moves when it is empty or the next one moves
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: quotients by 100 and 400, month table, time of day
	logic [cttu_pkg::YearW-1:0]       y1;
	logic [17:0]                      tod_pos;
	logic signed [cttu_pkg::TodW-1:0] tod_c;

	logic [cttu_pkg::YearW-1:0]       year_s1;
	logic [cttu_pkg::QuotW-1:0]       y1q100_s1, y1q400_s1, yq100_s1, yq400_s1;
	logic [cttu_pkg::StartW-1:0]      mstart_s1;
	logic                             late_s1;
	logic signed [cttu_pkg::DayW:0]   dm1_s1;
	logic signed [cttu_pkg::TodW-1:0] tod_s1;
	logic [cttu_pkg::MilliW-1:0]      milli_s1;

	assign y1      = year - 14'd1;
	assign tod_pos = 18'(hour) * 18'd3600 + 18'(minute) * 18'd60 + 18'(seconds);
	assign tod_c   = $signed({1'b0, tod_pos}) - cttu_pkg::TodW'(zone_offset_seconds);

	always_ff @(posedge clk) begin
		if (adv1) begin
			year_s1   <= year;
			y1q100_s1 <= cttu_pkg::div100(y1);
			y1q400_s1 <= cttu_pkg::div100({2'b00, y1[cttu_pkg::YearW-1:2]});
			yq100_s1  <= cttu_pkg::div100(year);
			yq400_s1  <= cttu_pkg::div100({2'b00, year[cttu_pkg::YearW-1:2]});
			mstart_s1 <= cttu_pkg::month_start(month);
			late_s1   <= (month > 4'd2);
			dm1_s1    <= $signed({1'b0, day_of_month}) - 6'sd1;
			tod_s1    <= tod_c;
			milli_s1  <= milliseconds;
		end
	end

	// Stage 2: whole-year days and the leap-year flag
	logic [cttu_pkg::YearW-1:0]   y1_b, whole;
	logic [12:0]                  leaps;
	logic [cttu_pkg::YearW-1:0]   r100;
	logic [cttu_pkg::YearW-3:0]   r400;
	logic                         is_leap;
	logic [cttu_pkg::YdayW-1:0]   yday_c;

	logic [cttu_pkg::YdayW-1:0]       yday_s2;
	logic                             leapadd_s2;
	logic [cttu_pkg::StartW-1:0]      mstart_s2;
	logic signed [cttu_pkg::DayW:0]   dm1_s2;
	logic signed [cttu_pkg::TodW-1:0] tod_s2;
	logic [cttu_pkg::MilliW-1:0]      milli_s2;

	assign y1_b  = year_s1 - 14'd1;
	assign whole = year_s1 - cttu_pkg::EpochYear;
	assign leaps = 13'(y1_b[cttu_pkg::YearW-1:2]) - 13'(y1q100_s1) + 13'(y1q400_s1)
	             - cttu_pkg::LeapsBeforeEpoch;
	assign r100  = year_s1 - 14'(yq100_s1) * 14'd100;
	assign r400  = year_s1[cttu_pkg::YearW-1:2] - 12'(yq400_s1) * 12'd100;
	// Divisible by 4, except centuries, unless divisible by 400
	assign is_leap = (year_s1[1:0] == 2'b00) && ((r100 != '0) || (r400 == '0));
	assign yday_c  = (year_s1 > cttu_pkg::EpochYear)
	               ? 23'(whole) * 23'(cttu_pkg::DaysPerYear) + 23'(leaps)
	               : '0;

	always_ff @(posedge clk) begin
		if (adv2) begin
			yday_s2    <= yday_c;
			leapadd_s2 <= late_s1 && is_leap;
			mstart_s2  <= mstart_s1;
			dm1_s2     <= dm1_s1;
			tod_s2     <= tod_s1;
			milli_s2   <= milli_s1;
		end
	end

	// Stage 3: total signed day count
	logic signed [cttu_pkg::DaysW-1:0] days_s3;
	logic signed [cttu_pkg::TodW-1:0]  tod_s3;
	logic [cttu_pkg::MilliW-1:0]       milli_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			days_s3  <= $signed({2'b00, yday_s2})
			          + $signed(cttu_pkg::DaysW'(mstart_s2))
			          + $signed(cttu_pkg::DaysW'(leapadd_s2))
			          + cttu_pkg::DaysW'(dm1_s2);
			tod_s3   <= tod_s2;
			milli_s3 <= milli_s2;
		end
	end

	assign out_valid = v_s3;
	assign days      = days_s3;
	assign tod       = tod_s3;
	assign milli     = milli_s3;

endmodule

// ----- design/cttu_scale.sv -----
// Scale half: day count and time of day to microseconds, modulo 2^64.
module cttu_scale (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cttu_pkg::DaysW-1:0]     days,
	input  logic signed [cttu_pkg::TodW-1:0]      tod,
	input  logic [cttu_pkg::MilliW-1:0]           milli,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cttu_pkg::MicrosW-1:0]          unix_micros
);

	// Stall chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	logic signed [cttu_pkg::SecsW-1:0]   dsec_s1;
	logic signed [cttu_pkg::TodW-1:0]    tod_s1;
	logic [cttu_pkg::MilliW-1:0]         milli_s1;
	logic signed [cttu_pkg::SecsW-1:0]   secs_s2;
	logic [cttu_pkg::MilliW-1:0]         milli_s2;
	logic signed [cttu_pkg::MicrosW-1:0] us_s3;
	logic [cttu_pkg::MsUsW-1:0]          msus_s3;
	logic signed [cttu_pkg::MicrosW-1:0] micros_s4;

	always_ff @(posedge clk) begin
		// Stage 1: days to seconds
		if (adv1) begin
			dsec_s1  <= cttu_pkg::SecsW'(days) * cttu_pkg::SecsW'(cttu_pkg::DaySeconds);
			tod_s1   <= tod;
			milli_s1 <= milli;
		end
		// Stage 2: add time of day (offset already removed)
		if (adv2) begin
			secs_s2  <= dsec_s1 + cttu_pkg::SecsW'(tod_s1);
			milli_s2 <= milli_s1;
		end
		// Stage 3: seconds to microseconds as (x * 15625) << 6
		if (adv3) begin
			us_s3   <= (cttu_pkg::MicrosW'(secs_s2)
			          * cttu_pkg::MicrosW'(cttu_pkg::Micros64th)) <<< 6;
			msus_s3 <= cttu_pkg::MsUsW'(milli_s2) * 20'd1000;
		end
		// Stage 4: add milliseconds, wraps at 64 bits
		if (adv4) begin
			micros_s4 <= us_s3 + $signed(cttu_pkg::MicrosW'(msus_s3));
		end
	end

	assign out_valid   = v_s4;
	assign unix_micros = unsigned'(micros_s4);

endmodule

// ----- design/civil_time_to_unix_micros_top.sv -----
// Civil date and time to Unix microseconds. Each request carries a Gregorian
// date, a time of day down to the millisecond and a zone offset in seconds;
// the result is microseconds since 1970-01-01 UTC, modulo 2^64, with no
// range checks on the fields. The block takes one request per clock while
// the output side is ready or some stage is empty, and its result is
// staged: three stages build the day count (reciprocal divides by 100 and
// 400, leap and whole-year terms, final day sum) and four scale it (times
// 86400, add time of day, times 10^6, add milliseconds). Every stage holds
// its own valid bit, so a stalled output fills empty stages first and
// requests keep being taken until the pipe is full.
`include "civil_time_to_unix_micros_top_macros.svh"

module civil_time_to_unix_micros_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cttu_pkg::YearW-1:0]            year,
	input  logic [cttu_pkg::MonthW-1:0]           month,
	input  logic [cttu_pkg::DayW-1:0]             day_of_month,
	input  logic [cttu_pkg::HourW-1:0]            hour,
	input  logic [cttu_pkg::MinW-1:0]             minute,
	input  logic [cttu_pkg::SecW-1:0]             seconds,
	input  logic [cttu_pkg::MilliW-1:0]           milliseconds,
	input  logic signed [cttu_pkg::OffsW-1:0]     zone_offset_seconds,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cttu_pkg::MicrosW-1:0]          unix_micros
);

	logic                              mid_valid;
	logic                              mid_ready;
	logic signed [cttu_pkg::DaysW-1:0] mid_days;
	logic signed [cttu_pkg::TodW-1:0]  mid_tod;
	logic [cttu_pkg::MilliW-1:0]       mid_milli;

	// Date to day count
	cttu_date u_date (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.year                (year),
		.month               (month),
		.day_of_month        (day_of_month),
		.hour                (hour),
		.minute              (minute),
		.seconds             (seconds),
		.milliseconds        (milliseconds),
		.zone_offset_seconds (zone_offset_seconds),
		.out_valid           (mid_valid),
		.out_ready           (mid_ready),
		.days                (mid_days),
		.tod                 (mid_tod),
		.milli               (mid_milli)
	);

	// Day count to microseconds
	cttu_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mid_valid),
		.in_ready    (mid_ready),
		.days        (mid_days),
		.tod         (mid_tod),
		.milli       (mid_milli),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.unix_micros (unix_micros)
	);

	// A ready sink lets the whole pipe move
	`CTTU_ASSERT_NOW(a_ready_flows, out_ready, in_ready)
	// An empty output stage always leaves room upstream
	`CTTU_ASSERT_NOW(a_empty_out_ready, !out_valid, in_ready)
	// A day count held at the boundary is not dropped
	`CTTU_ASSERT_NEXT(a_mid_hold, mid_valid && !mid_ready, mid_valid)

endmodule
